[rtl/wtsc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wtsc_pkg;

    localparam int unsigned TICKS_PER_WAVE_CLOCK_DEF = 8;
    localparam int unsigned STEPS_PER_BANK_DEF       = 32;

    localparam int unsigned RATE_BASE    = 2048;
    localparam int unsigned RATE_W       = 11;
    localparam int unsigned BANK_BYTES   = 16;
    localparam int unsigned BYTE_IDX_W   = 4;
    localparam int unsigned MEM_ADDR_W   = BYTE_IDX_W + 1;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = RATE_W;
    localparam int unsigned SAMPLE_W     = 8;
    localparam logic [3:0]  NIBBLE_BIAS  = 4'd8;
    localparam logic [2:0]  FORCED_MULT  = 3'd3;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_TRIGGER = 2'd1,
        FUNC_STOP    = 2'd2,
        FUNC_WRITE   = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLAYBACK_ENABLE = 3'd0,
        REG_TWO_BANK_MODE   = 3'd1,
        REG_START_BANK      = 3'd2,
        REG_LEN_GATE        = 3'd3,
        REG_VOL_FORCE       = 3'd4,
        REG_VOLUME_CODE     = 3'd5,
        REG_RATE_VALUE      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic              playback_enable;
        logic              two_bank_mode;
        logic              start_bank;
        logic              len_gate_en;
        logic              vol_force;
        logic [1:0]        volume_code;
        logic [RATE_W-1:0] rate_value;
    } t_cfg;

    typedef struct packed {
        logic [1:0] func;
        logic       length_nonzero;
        logic       write_bank;
        logic [3:0] write_index;
        logic [7:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       playing;
        logic                       stepped;
    } t_out_item;

    typedef struct packed {
        logic                  we;
        logic [MEM_ADDR_W-1:0] addr;
        logic [7:0]            data;
    } t_mem_wr;

    typedef struct packed {
        logic running;
        logic cnt_zero;
        logic pos_zero;
    } t_eng_stat;

    // volume multiplier: mute, x4, x2, x1; forced volume gives x3
    function automatic logic [2:0] vol_mult(input logic force_vol, input logic [1:0] code);
        logic [2:0] m;
        if (force_vol) begin
            m = FORCED_MULT;
        end else begin
            unique case (code)
                2'd0: m = 3'd0;
                2'd1: m = 3'd4;
                2'd2: m = 3'd2;
                default: m = 3'd1;
            endcase
        end
        return m;
    endfunction

endpackage

`default_nettype wire

[rtl/wtsc_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface wtsc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic       length_nonzero;
    logic       write_bank;
    logic [3:0] write_index;
    logic [7:0] write_data;

    modport source (
        output valid, func, length_nonzero, write_bank, write_index, write_data,
        input  ready
    );
    modport sink (
        input  valid, func, length_nonzero, write_bank, write_index, write_data,
        output ready
    );
endinterface

`default_nettype wire

[rtl/wtsc_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface wtsc_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] sample_out;
    logic              playing;
    logic              stepped;

    modport source (
        output valid, sample_out, playing, stepped,
        input  ready
    );
    modport sink (
        input  valid, sample_out, playing, stepped,
        output ready
    );
endinterface

`default_nettype wire

[rtl/wtsc_cfg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none

module wtsc_cfg_regs (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [wtsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [wtsc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output wtsc_pkg::t_cfg                       o_cfg
);

    wtsc_pkg::t_cfg r_cfg;
    wtsc_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wtsc_pkg::REG_PLAYBACK_ENABLE: n_cfg.playback_enable = i_cfg_data[0];
                wtsc_pkg::REG_TWO_BANK_MODE:   n_cfg.two_bank_mode   = i_cfg_data[0];
                wtsc_pkg::REG_START_BANK:      n_cfg.start_bank      = i_cfg_data[0];
                wtsc_pkg::REG_LEN_GATE:        n_cfg.len_gate_en     = i_cfg_data[0];
                wtsc_pkg::REG_VOL_FORCE:       n_cfg.vol_force       = i_cfg_data[0];
                wtsc_pkg::REG_VOLUME_CODE:     n_cfg.volume_code     = i_cfg_data[1:0];
                wtsc_pkg::REG_RATE_VALUE:      n_cfg.rate_value      = i_cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/wtsc_wave_mem.sv]
`timescale 1ns / 1ps
`default_nettype none

module wtsc_wave_mem (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wtsc_pkg::t_mem_wr                    i_wr,
    input  wire logic [wtsc_pkg::MEM_ADDR_W-1:0] i_raddr,
    output logic [7:0]                           o_rdata
);

    localparam int unsigned DEPTH = 2 * wtsc_pkg::BANK_BYTES;

    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_mem[k] <= '0;
            end
        end else if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rdata = r_mem[i_raddr];

endmodule

`default_nettype wire

[rtl/wtsc_engine.sv]
`timescale 1ns / 1ps
`default_nettype none

module wtsc_engine #(
    parameter int unsigned TICKS_PER_WAVE_CLOCK = wtsc_pkg::TICKS_PER_WAVE_CLOCK_DEF,
    parameter int unsigned STEPS_PER_BANK       = wtsc_pkg::STEPS_PER_BANK_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wtsc_pkg::t_cfg                       i_cfg,
    input  wire logic                            i_advance,
    input  wtsc_pkg::t_in_item                   i_item,
    input  wire logic [7:0]                      i_mem_rdata,
    output logic [wtsc_pkg::MEM_ADDR_W-1:0]      o_mem_raddr,
    output wtsc_pkg::t_mem_wr                    o_mem_wr,
    output wtsc_pkg::t_out_item                  o_result,
    output wtsc_pkg::t_eng_stat                  o_stat
);

    localparam int unsigned POS_W    = $clog2(STEPS_PER_BANK);
    localparam int unsigned POS_XW   = 7;
    localparam int unsigned CNT_W    = $clog2(TICKS_PER_WAVE_CLOCK * wtsc_pkg::RATE_BASE);
    localparam int unsigned PERIOD_W = CNT_W + 1;
    localparam int unsigned SPAN_W   = wtsc_pkg::RATE_W + 1;

    logic [POS_W-1:0]            r_pos, n_pos;
    logic                        r_bank, n_bank;
    logic                        r_running, n_running;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [wtsc_pkg::SAMPLE_W-1:0] r_latch, n_latch;
    logic                        r_status, n_status;

    logic [POS_XW-1:0]           pos_wide;
    logic [POS_W:0]              pos_inc;
    logic [3:0]                  nibble;
    logic signed [4:0]           centered;
    logic signed [7:0]           gated;
    logic signed [7:0]           mult;
    logic signed [7:0]           scaled;
    logic [SPAN_W-1:0]           rate_span;
    logic [PERIOD_W-1:0]         period;
    logic                        stepped;

    // read address follows the play position: (position / 2) mod 16 in the playing bank
    assign pos_wide    = POS_XW'(r_pos);
    assign o_mem_raddr = {r_bank, pos_wide[4:1]};

    assign nibble   = r_pos[0] ? i_mem_rdata[3:0] : i_mem_rdata[7:4];
    assign centered = $signed({1'b0, nibble}) - $signed({1'b0, wtsc_pkg::NIBBLE_BIAS});
    assign gated    = (i_cfg.len_gate_en && !i_item.length_nonzero) ? 8'sd0 : 8'(centered);
    assign mult     = $signed({5'b0, wtsc_pkg::vol_mult(i_cfg.vol_force,
                                                        i_cfg.volume_code)});
    assign scaled   = (gated * mult) <<< 2;

    assign rate_span = SPAN_W'(wtsc_pkg::RATE_BASE) - SPAN_W'(i_cfg.rate_value);
    assign period    = PERIOD_W'(TICKS_PER_WAVE_CLOCK) * PERIOD_W'(rate_span);
    assign pos_inc   = (POS_W + 1)'(r_pos) + (POS_W + 1)'(1);

    always_comb begin
        n_pos     = r_pos;
        n_bank    = r_bank;
        n_running = r_running;
        n_cnt     = r_cnt;
        n_latch   = r_latch;
        n_status  = r_status;
        stepped   = 1'b0;
        o_mem_wr  = '{we: 1'b0, addr: {i_item.write_bank, i_item.write_index},
                      data: i_item.write_data};
        if (i_advance) begin
            unique case (wtsc_pkg::t_func'(i_item.func))
                wtsc_pkg::FUNC_TICK: begin
                    if (r_running) begin
                        if (r_cnt == '0) begin
                            stepped = 1'b1;
                            if (!i_cfg.playback_enable) begin
                                n_status  = 1'b0;
                                n_latch   = '0;
                                n_pos     = '0;
                                n_running = 1'b0;
                                n_cnt     = '0;
                            end else begin
                                n_status = 1'b1;
                                n_latch  = scaled;
                                n_cnt    = CNT_W'(period - PERIOD_W'(1));
                                if (pos_inc >= (POS_W + 1)'(STEPS_PER_BANK)) begin
                                    n_pos = '0;
                                    if (i_cfg.two_bank_mode) begin
                                        n_bank = ~r_bank;
                                    end
                                end else begin
                                    n_pos = pos_inc[POS_W-1:0];
                                end
                            end
                        end else begin
                            n_cnt = r_cnt - CNT_W'(1);
                        end
                    end
                end
                wtsc_pkg::FUNC_TRIGGER: begin
                    // first step lands on the next tick
                    n_status  = 1'b0;
                    n_latch   = '0;
                    n_pos     = '0;
                    n_running = 1'b1;
                    n_bank    = i_cfg.start_bank;
                    n_cnt     = '0;
                end
                wtsc_pkg::FUNC_STOP: begin
                    n_status  = 1'b0;
                    n_latch   = '0;
                    n_pos     = '0;
                    n_running = 1'b0;
                    n_cnt     = '0;
                end
                wtsc_pkg::FUNC_WRITE: begin
                    o_mem_wr.we = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_bank    <= 1'b0;
            r_running <= 1'b0;
            r_cnt     <= '0;
            r_latch   <= '0;
            r_status  <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_bank    <= n_bank;
            r_running <= n_running;
            r_cnt     <= n_cnt;
            r_latch   <= n_latch;
            r_status  <= n_status;
        end
    end

    // result reflects the state this item leaves behind
    assign o_result = '{sample_out: $signed(n_latch), playing: n_status, stepped: stepped};
    assign o_stat   = '{running: r_running, cnt_zero: (r_cnt == '0), pos_zero: (r_pos == '0)};

endmodule

`default_nettype wire

[rtl/wave_table_sound_channel.sv]
`timescale 1ns / 1ps
`default_nettype none

// Wave-table sound channel.
// i_in carries one item per system tick: a tick, a trigger, a stop or a
// wave memory byte write; o_out returns one result per item: the latched
// sample, the playing flag and a flag for a wave step on that item.
// Registers are to be written through i_cfg_we / i_cfg_idx / i_cfg_data
// while no item is in flight; the block does not enforce this. They take
// effect on the next item. An accepted item sits in an input register;
// when the result register is free or draining, the step logic (period
// product, wave byte read, volume scaling) updates the channel state and
// loads the result register. One item per cycle is sustained while o_out
// is ready; the rate is set by the combinational step path in between.
// Reset clears registers, channel state and the 32-byte wave memory at once;
// items are taken in the first cycle after reset.
// When the receiver stalls, the result register holds; the input register
// takes one more item and then i_in.ready drops until o_out moves.

module wave_table_sound_channel #(
    parameter int unsigned TICKS_PER_WAVE_CLOCK = wtsc_pkg::TICKS_PER_WAVE_CLOCK_DEF,
    parameter int unsigned STEPS_PER_BANK       = wtsc_pkg::STEPS_PER_BANK_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    wtsc_in_if.sink                              i_in,
    wtsc_out_if.source                           o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [wtsc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [wtsc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    wtsc_pkg::t_cfg       cfg;
    wtsc_pkg::t_in_item   r_item;
    logic                 r_in_valid;
    wtsc_pkg::t_out_item  r_out;
    wtsc_pkg::t_out_item  result;
    logic                 r_out_valid;
    logic                 advance;
    logic                 in_take;
    wtsc_pkg::t_mem_wr    mem_wr;
    logic [wtsc_pkg::MEM_ADDR_W-1:0] mem_raddr;
    logic [7:0]           mem_rdata;
    wtsc_pkg::t_eng_stat  stat;

    wtsc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    wtsc_wave_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (mem_wr),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    wtsc_engine #(
        .TICKS_PER_WAVE_CLOCK (TICKS_PER_WAVE_CLOCK),
        .STEPS_PER_BANK       (STEPS_PER_BANK)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_advance   (advance),
        .i_item      (r_item),
        .i_mem_rdata (mem_rdata),
        .o_mem_raddr (mem_raddr),
        .o_mem_wr    (mem_wr),
        .o_result    (result),
        .o_stat      (stat)
    );

    // move the held item on when the result register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= '{func: i_in.func, length_nonzero: i_in.length_nonzero,
                        write_bank: i_in.write_bank, write_index: i_in.write_index,
                        write_data: i_in.write_data};
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out.sample_out;
    assign o_out.playing    = r_out.playing;
    assign o_out.stepped    = r_out.stepped;

    a_stopped_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.playing) |-> (o_out.sample_out == '0))
        else $error("stopped channel shows a nonzero sample");

    a_idle_state_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !stat.running |-> (stat.cnt_zero && stat.pos_zero))
        else $error("idle channel keeps a count or position");

    a_free_output_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled while result register is empty");

    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_out.valid)
        else $error("processed item produced no result");

endmodule

`default_nettype wire

[tb/sv/wave_table_sound_channel_tb.sv]
`timescale 1ns / 1ps

module wave_table_sound_channel_tb;

    localparam int unsigned WAVE_TICKS  = wtsc_pkg::TICKS_PER_WAVE_CLOCK_DEF;
    localparam int unsigned BANK_STEPS  = wtsc_pkg::STEPS_PER_BANK_DEF;
    localparam int unsigned VOL_SCALE [4] = '{0, 4, 2, 1};
    localparam int unsigned SOAK_TICKS  = 40;
    localparam longint unsigned CYCLE_LIMIT = 200_000;

    typedef enum logic [1:0] {
        SOP_ITEM,
        SOP_CFG,
        SOP_DRAIN
    } t_stim_kind;

    typedef struct {
        t_stim_kind                      kind;
        wtsc_pkg::t_in_item              item;
        wtsc_pkg::t_cfg_idx              reg_idx;
        logic [wtsc_pkg::CFG_DATA_W-1:0] reg_val;
    } t_stim_op;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [wtsc_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [wtsc_pkg::CFG_DATA_W-1:0] cfg_data;

    wtsc_in_if  in_ch ();
    wtsc_out_if out_ch ();

    wave_table_sound_channel uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // channel model state
    logic [7:0]          wave_bytes [2][wtsc_pkg::BANK_BYTES];
    logic [5:0]          play_pos;
    logic                play_bank;
    logic                chan_running;
    logic [14:0]         tick_count;
    logic [7:0]          held_sample;
    logic                playing_flag;
    wtsc_pkg::t_cfg      chan_cfg;

    t_stim_op            pending_ops [$];
    wtsc_pkg::t_out_item expected_samples [$];
    int unsigned         items_accepted;
    int unsigned         results_done;
    int unsigned         fail_count;
    int unsigned         send_gap;
    int unsigned         send_calm;
    int unsigned         recv_stall;
    int unsigned         recv_calm;
    longint unsigned     cycle_count;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned draw_idle(inout int unsigned calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic silence_channel();
        playing_flag = 1'b0;
        held_sample  = '0;
        play_pos     = '0;
        chan_running = 1'b0;
    endtask

    // advance the channel by one item and return the status it leaves
    task automatic advance_channel(input wtsc_pkg::t_in_item it,
                                   output wtsc_pkg::t_out_item res);
        logic [7:0]  wbyte;
        logic [3:0]  nib;
        int          sval;
        int unsigned mult;
        int unsigned period;
        logic        hit;
        hit = 1'b0;
        case (it.func)
            wtsc_pkg::FUNC_TICK: begin
                if (chan_running) begin
                    if (tick_count == 0) begin
                        period = WAVE_TICKS
                                 * (wtsc_pkg::RATE_BASE - int'(chan_cfg.rate_value));
                        hit = 1'b1;
                        if (!chan_cfg.playback_enable) begin
                            silence_channel();
                        end else begin
                            playing_flag = 1'b1;
                            wbyte = wave_bytes[play_bank][play_pos[4:1]];
                            nib = play_pos[0] ? wbyte[3:0] : wbyte[7:4];
                            sval = int'(nib) - int'(wtsc_pkg::NIBBLE_BIAS);
                            if (chan_cfg.len_gate_en && !it.length_nonzero) sval = 0;
                            mult = chan_cfg.vol_force ? int'(wtsc_pkg::FORCED_MULT)
                                                      : VOL_SCALE[chan_cfg.volume_code];
                            sval = sval * int'(mult) * 4;
                            held_sample = sval[7:0];
                            play_pos = play_pos + 1'b1;
                            if (play_pos >= BANK_STEPS) begin
                                play_pos = '0;
                                if (chan_cfg.two_bank_mode) play_bank = ~play_bank;
                            end
                        end
                        tick_count = chan_running ? 15'(period - 1) : '0;
                    end else begin
                        tick_count = tick_count - 1'b1;
                    end
                end
            end
            wtsc_pkg::FUNC_TRIGGER: begin
                silence_channel();
                chan_running = 1'b1;
                play_pos     = '0;
                play_bank    = chan_cfg.start_bank;
                tick_count   = '0;
            end
            wtsc_pkg::FUNC_STOP: begin
                silence_channel();
                tick_count = '0;
            end
            default: begin
                wave_bytes[it.write_bank][it.write_index] = it.write_data;
            end
        endcase
        res.sample_out = held_sample;
        res.playing    = playing_flag;
        res.stepped    = hit;
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    // driver: one item, register write or drain per free slot
    always @(posedge i_clk) begin
        logic                            nxt_valid;
        wtsc_pkg::t_in_item              nxt_item;
        logic                            nxt_we;
        logic [wtsc_pkg::CFG_IDX_W-1:0]  nxt_idx;
        logic [wtsc_pkg::CFG_DATA_W-1:0] nxt_data;
        wtsc_pkg::t_in_item              cur_item;
        wtsc_pkg::t_out_item             predicted;
        t_stim_op                        op;
        logic                            idle_now;
        cur_item.func           = in_ch.func;
        cur_item.length_nonzero = in_ch.length_nonzero;
        cur_item.write_bank     = in_ch.write_bank;
        cur_item.write_index    = in_ch.write_index;
        cur_item.write_data     = in_ch.write_data;
        nxt_item  = cur_item;
        nxt_valid = in_ch.valid;
        nxt_we    = 1'b0;
        nxt_idx   = cfg_idx;
        nxt_data  = cfg_data;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                advance_channel(cur_item, predicted);
                expected_samples.push_back(predicted);
                items_accepted++;
                nxt_valid = 1'b0;
            end
            idle_now = (items_accepted == results_done);
            if (!nxt_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_ops.size() > 0) begin
                    op = pending_ops[0];
                    case (op.kind)
                        SOP_ITEM: begin
                            nxt_item  = op.item;
                            nxt_valid = 1'b1;
                            void'(pending_ops.pop_front());
                            send_gap = draw_idle(send_calm);
                        end
                        SOP_CFG: begin
                            if (idle_now) begin
                                nxt_we   = 1'b1;
                                nxt_idx  = op.reg_idx;
                                nxt_data = op.reg_val;
                                case (op.reg_idx)
                                    wtsc_pkg::REG_PLAYBACK_ENABLE:
                                        chan_cfg.playback_enable = op.reg_val[0];
                                    wtsc_pkg::REG_TWO_BANK_MODE:
                                        chan_cfg.two_bank_mode   = op.reg_val[0];
                                    wtsc_pkg::REG_START_BANK:
                                        chan_cfg.start_bank      = op.reg_val[0];
                                    wtsc_pkg::REG_LEN_GATE:
                                        chan_cfg.len_gate_en     = op.reg_val[0];
                                    wtsc_pkg::REG_VOL_FORCE:
                                        chan_cfg.vol_force       = op.reg_val[0];
                                    wtsc_pkg::REG_VOLUME_CODE:
                                        chan_cfg.volume_code     = op.reg_val[1:0];
                                    default:
                                        chan_cfg.rate_value      = op.reg_val;
                                endcase
                                void'(pending_ops.pop_front());
                            end
                        end
                        default: begin
                            if (idle_now) void'(pending_ops.pop_front());
                        end
                    endcase
                end
            end
        end
        in_ch.valid          <= nxt_valid;
        in_ch.func           <= nxt_item.func;
        in_ch.length_nonzero <= nxt_item.length_nonzero;
        in_ch.write_bank     <= nxt_item.write_bank;
        in_ch.write_index    <= nxt_item.write_index;
        in_ch.write_data     <= nxt_item.write_data;
        cfg_we               <= nxt_we;
        cfg_idx              <= nxt_idx;
        cfg_data             <= nxt_data;
    end

    // monitor: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        wtsc_pkg::t_out_item want;
        logic                nxt_ready;
        logic                took;
        nxt_ready = 1'b0;
        if (i_rst_n) begin
            took = out_ch.valid && out_ch.ready;
            if (took) begin
                results_done <= results_done + 1;
                if (expected_samples.size() == 0) begin
                    note_failure($sformatf("unexpected result: sample %0d playing %0b stepped %0b",
                                           out_ch.sample_out, out_ch.playing, out_ch.stepped));
                end else begin
                    want = expected_samples.pop_front();
                    if (out_ch.sample_out !== want.sample_out || out_ch.playing !== want.playing
                            || out_ch.stepped !== want.stepped) begin
                        note_failure($sformatf({"mismatch at result %0d: expected sample %0d ",
                                                "playing %0b stepped %0b, got sample %0d ",
                                                "playing %0b stepped %0b"},
                                               results_done, want.sample_out, want.playing,
                                               want.stepped, out_ch.sample_out,
                                               out_ch.playing, out_ch.stepped));
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
            end else if (took) begin
                recv_stall = draw_idle(recv_calm);
                nxt_ready  = (recv_stall == 0);
            end else begin
                nxt_ready = 1'b1;
            end
        end
        out_ch.ready <= nxt_ready;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("wave_table_sound_channel regression: fail");
            $finish;
        end
    end

    task automatic queue_item(input wtsc_pkg::t_func f, input logic len, input logic bank,
                              input logic [3:0] idx, input logic [7:0] data);
        t_stim_op op;
        op.kind                = SOP_ITEM;
        op.item.func           = f;
        op.item.length_nonzero = len;
        op.item.write_bank     = bank;
        op.item.write_index    = idx;
        op.item.write_data     = data;
        op.reg_idx             = wtsc_pkg::REG_PLAYBACK_ENABLE;
        op.reg_val             = '0;
        pending_ops.push_back(op);
    endtask

    task automatic queue_tick(input logic len);
        queue_item(wtsc_pkg::FUNC_TICK, len, 1'($urandom), 4'($urandom), 8'($urandom));
    endtask

    task automatic queue_drain();
        t_stim_op op;
        op.kind    = SOP_DRAIN;
        op.item    = '0;
        op.reg_idx = wtsc_pkg::REG_PLAYBACK_ENABLE;
        op.reg_val = '0;
        pending_ops.push_back(op);
    endtask

    task automatic queue_setting(input logic pe, input logic two_bank, input logic sbank,
                                 input logic use_len, input logic force_vol,
                                 input logic [1:0] vol,
                                 input logic [wtsc_pkg::RATE_W-1:0] rate);
        t_stim_op op;
        logic [wtsc_pkg::CFG_DATA_W-1:0] vals [7];
        vals = '{wtsc_pkg::CFG_DATA_W'(pe), wtsc_pkg::CFG_DATA_W'(two_bank),
                 wtsc_pkg::CFG_DATA_W'(sbank), wtsc_pkg::CFG_DATA_W'(use_len),
                 wtsc_pkg::CFG_DATA_W'(force_vol), wtsc_pkg::CFG_DATA_W'(vol), rate};
        op.kind = SOP_CFG;
        op.item = '0;
        for (int i = 0; i < 7; i++) begin
            op.reg_idx = wtsc_pkg::t_cfg_idx'(i);
            op.reg_val = vals[i];
            pending_ops.push_back(op);
        end
    endtask

    // mostly ticks with random writes; triggers and stops at the given rate
    task automatic queue_play(input int unsigned count, input int unsigned disturb_pct);
        int unsigned     r;
        wtsc_pkg::t_func f;
        queue_item(wtsc_pkg::FUNC_TRIGGER, 1'($urandom), 1'($urandom), 4'($urandom),
                   8'($urandom));
        for (int unsigned n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < disturb_pct / 2)           f = wtsc_pkg::FUNC_TRIGGER;
            else if (r < disturb_pct)          f = wtsc_pkg::FUNC_STOP;
            else if (r < disturb_pct + 12)     f = wtsc_pkg::FUNC_WRITE;
            else                               f = wtsc_pkg::FUNC_TICK;
            queue_item(f, 1'($urandom), 1'($urandom), 4'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.func           = wtsc_pkg::FUNC_TICK;
        in_ch.length_nonzero = 1'b0;
        in_ch.write_bank     = 1'b0;
        in_ch.write_index    = '0;
        in_ch.write_data     = '0;
        out_ch.ready         = 1'b0;
        cfg_we               = 1'b0;
        cfg_idx              = '0;
        cfg_data             = '0;
        i_rst_n              = 1'b0;
        for (int b = 0; b < 2; b++)
            for (int i = 0; i < wtsc_pkg::BANK_BYTES; i++) wave_bytes[b][i] = '0;
        play_pos       = '0;
        play_bank      = 1'b0;
        chan_running   = 1'b0;
        tick_count     = '0;
        held_sample    = '0;
        playing_flag   = 1'b0;
        chan_cfg       = '0;
        items_accepted = 0;
        results_done   = 0;
        fail_count     = 0;
        send_gap       = 0;
        send_calm      = 0;
        recv_stall     = 0;
        recv_calm      = 0;
        cycle_count    = 0;

        // reset settings: idle tick, then a step with playback off stops play
        queue_tick(1'b1);
        queue_item(wtsc_pkg::FUNC_TRIGGER, 1'b1, 1'b0, 4'd0, 8'd0);
        queue_tick(1'b1);
        queue_tick(1'b1);

        // full volume, fastest rate: extreme nibbles, length gating, restarts
        queue_setting(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 2'd1, 11'd2047);
        queue_item(wtsc_pkg::FUNC_WRITE, 1'b0, 1'b0, 4'd0, 8'h0F);
        queue_item(wtsc_pkg::FUNC_WRITE, 1'b1, 1'b1, 4'd0, 8'hF0);
        queue_item(wtsc_pkg::FUNC_WRITE, 1'b0, 1'b0, 4'd15, 8'hFF);
        queue_item(wtsc_pkg::FUNC_WRITE, 1'b1, 1'b1, 4'd15, 8'h00);
        queue_item(wtsc_pkg::FUNC_TRIGGER, 1'b1, 1'b0, 4'd0, 8'd0);
        queue_tick(1'b1);
        for (int i = 0; i < 7; i++) queue_tick(1'($urandom));
        queue_tick(1'b1);
        for (int i = 0; i < 7; i++) queue_tick(1'($urandom));
        queue_tick(1'b0);
        queue_item(wtsc_pkg::FUNC_TRIGGER, 1'b1, 1'b1, 4'd3, 8'd0);
        queue_item(wtsc_pkg::FUNC_STOP, 1'b1, 1'b0, 4'd0, 8'd0);
        queue_tick(1'b1);

        // long play in two-bank mode starting from bank 1, then mixed settings
        queue_setting(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 2'd0, 11'd2047);
        queue_play(100, 2);
        queue_drain();
        queue_play(100, 2);
        queue_setting(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 2'd2, 11'd2046);
        queue_play(40, 8);
        queue_setting(1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 2'd3, 11'd2043);
        queue_play(40, 8);
        queue_setting(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 2'd1, 11'd2047);
        queue_play(20, 8);
        queue_setting(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 11'd2045);
        queue_play(20, 8);
        for (int i = 0; i < 2; i++) begin
            queue_setting(1'b1, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                          2'($urandom), 11'($urandom_range(2036, 2047)));
            queue_play(30, 10);
        end
        queue_setting(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 2'd1, 11'd1800);
        queue_play(40, 1);

        // slowest rate: first step at once, then a long countdown
        queue_setting(1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 2'd1, 11'd0);
        queue_item(wtsc_pkg::FUNC_TRIGGER, 1'b1, 1'b0, 4'd0, 8'd0);
        for (int unsigned i = 0; i < SOAK_TICKS; i++) queue_tick(1'($urandom));
        queue_item(wtsc_pkg::FUNC_STOP, 1'b0, 1'b0, 4'd0, 8'd0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_ops.size() != 0 || in_ch.valid || expected_samples.size() != 0)
            @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && expected_samples.size() == 0) begin
            $display("wave_table_sound_channel regression: pass");
        end else begin
            $display("wave_table_sound_channel regression: fail");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/wtsc_pkg.sv
rtl/wtsc_in_if.sv
rtl/wtsc_out_if.sv
rtl/wtsc_cfg_regs.sv
rtl/wtsc_wave_mem.sv
rtl/wtsc_engine.sv
rtl/wave_table_sound_channel.sv
tb/sv/wave_table_sound_channel_tb.sv
